### rtl/kmwt_pkg.sv
// ----------------------------------------------------------------------------
// kmwt_pkg: shared types and codes for the keyed max window table
// Request and response payloads, table entry layout, action codes and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package kmwt_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned PosW  = 6;

  typedef enum logic [2:0] {
    ACT_LOAD   = 3'd0,
    ACT_MERGE  = 3'd1,
    ACT_LOOKUP = 3'd2,
    ACT_LIST   = 3'd3,
    ACT_CLEAR  = 3'd4
  } kmwt_action_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_WALK   = 2'd1,
    ST_COMMIT = 2'd2
  } kmwt_state_e;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [TimeW-1:0] key_time;
    logic signed [TimeW-1:0] yield_value;
  } kmwt_req_t;

  typedef struct packed {
    logic                    accepted;
    logic                    entry_valid;
    logic [PosW-1:0]         position;
    logic signed [TimeW-1:0] entry_time;
    logic signed [TimeW-1:0] entry_yield;
    logic                    last;
  } kmwt_rsp_t;

  typedef struct packed {
    logic signed [TimeW-1:0] tstamp;
    logic signed [TimeW-1:0] yld;
  } kmwt_entry_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } kmwt_cmp_t;

  // result offered by the sequencer to the output register
  typedef struct packed {
    logic      vld;
    logic      clr_ready;
    kmwt_rsp_t rsp;
  } kmwt_emit_t;

endpackage

### rtl/kmwt_cmp.sv
// ----------------------------------------------------------------------------
// kmwt_cmp: shared signed comparator
// Equality and signed greater-than of two 32-bit operands; used for key match,
// newer-than test and yield maximum.
// ----------------------------------------------------------------------------
module kmwt_cmp (
  input  logic signed [kmwt_pkg::TimeW-1:0] a_i,
  input  logic signed [kmwt_pkg::TimeW-1:0] b_i,
  output kmwt_pkg::kmwt_cmp_t               res_o
);

  assign res_o.eq = (a_i == b_i);
  assign res_o.gt = (a_i > b_i);

endmodule

### rtl/kmwt_store.sv
// ----------------------------------------------------------------------------
// kmwt_store: entry memory
// One write port, one read port with registered read data that holds while
// no read is enabled.
// ----------------------------------------------------------------------------
module kmwt_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  kmwt_pkg::kmwt_entry_t wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output kmwt_pkg::kmwt_entry_t rdata_o
);

  kmwt_pkg::kmwt_entry_t mem_q [DEPTH];
  kmwt_pkg::kmwt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/kmwt_ctrl.sv
// ----------------------------------------------------------------------------
// kmwt_ctrl: request sequencer
// Walks occupied entries newest to oldest through the memory read port,
// drives the shared comparator and commits table updates and results.
// ----------------------------------------------------------------------------
module kmwt_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  kmwt_pkg::kmwt_req_t   in_data_i,
  output logic                  idle_o,
  input  logic                  table_ready_i,
  output kmwt_pkg::kmwt_emit_t  emit_o,
  input  logic                  emit_ok_i,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  kmwt_pkg::kmwt_entry_t mem_rdata_i,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output kmwt_pkg::kmwt_entry_t mem_wdata_o
);

  localparam int unsigned SW = CW + 1;

  kmwt_pkg::kmwt_state_e state_q, state_d;
  kmwt_pkg::kmwt_req_t   req_q, req_d;
  kmwt_pkg::kmwt_rsp_t   pend_q, pend_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         oldest_q, oldest_d;
  logic [AW-1:0]         issue_idx_q, issue_idx_d;
  logic                  issue_more_q, issue_more_d;
  logic                  data_vld_q, data_vld_d;
  logic [AW-1:0]         data_idx_q, data_idx_d;
  logic [AW-1:0]         data_slot_q, data_slot_d;
  logic                  found_q, found_d;
  logic [AW-1:0]         found_slot_q, found_slot_d;
  logic                  pend_vld_q, pend_vld_d;

  logic signed [kmwt_pkg::TimeW-1:0] cmp_a, cmp_b;
  kmwt_pkg::kmwt_cmp_t               cmp;

  logic [CW-1:0] slot_lg;
  logic [AW-1:0] slot;
  logic [CW-1:0] cnt_m1;
  logic          is_srch, is_list, walk_start, hit, list_hit, walk_end;
  logic          list_push, adv, has_room;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] lg);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(lg);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  kmwt_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp)
  );

  assign is_srch  = (req_q.action == kmwt_pkg::ACT_MERGE) ||
                    (req_q.action == kmwt_pkg::ACT_LOOKUP);
  assign is_list  = (req_q.action == kmwt_pkg::ACT_LIST);
  assign hit      = data_vld_q && cmp.eq;
  assign list_hit = data_vld_q && cmp.gt;
  assign walk_end = data_vld_q && (data_idx_q == '0);
  assign has_room = (count_q < CW'(DEPTH));
  assign cnt_m1   = count_q - CW'(1);

  // hold the walk while an older list result cannot leave
  assign list_push = (state_q == kmwt_pkg::ST_WALK) && is_list && list_hit && pend_vld_q;
  assign adv       = !(list_push && !emit_ok_i);

  assign walk_start = (count_q != '0) &&
                      ((((in_data_i.action == kmwt_pkg::ACT_MERGE) ||
                         (in_data_i.action == kmwt_pkg::ACT_LOOKUP)) && table_ready_i) ||
                       (in_data_i.action == kmwt_pkg::ACT_LIST));

  // shared ring adder: walk index while walking, append slot when committing
  assign slot_lg = (state_q == kmwt_pkg::ST_COMMIT) ? count_q : CW'(issue_idx_q);
  assign slot    = slot_of(oldest_q, slot_lg);

  always_comb begin
    if (state_q == kmwt_pkg::ST_COMMIT) begin
      cmp_a = req_q.yield_value;
      cmp_b = pend_q.entry_yield;
    end else begin
      cmp_a = mem_rdata_i.tstamp;
      cmp_b = req_q.key_time;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kmwt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = walk_start ? kmwt_pkg::ST_WALK : kmwt_pkg::ST_COMMIT;
        end
      end
      kmwt_pkg::ST_WALK: begin
        if (adv && ((is_srch && hit) || walk_end)) begin
          state_d = kmwt_pkg::ST_COMMIT;
        end
      end
      kmwt_pkg::ST_COMMIT: begin
        if (emit_ok_i) begin
          state_d = kmwt_pkg::ST_IDLE;
        end
      end
      default: state_d = kmwt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_d        = req_q;
    pend_d       = pend_q;
    count_d      = count_q;
    oldest_d     = oldest_q;
    issue_idx_d  = issue_idx_q;
    issue_more_d = issue_more_q;
    data_vld_d   = data_vld_q;
    data_idx_d   = data_idx_q;
    data_slot_d  = data_slot_q;
    found_d      = found_q;
    found_slot_d = found_slot_q;
    pend_vld_d   = pend_vld_q;
    idle_o       = 1'b0;
    emit_o       = '0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = slot;
    mem_we_o     = 1'b0;
    mem_waddr_o  = slot;
    mem_wdata_o.tstamp = req_q.key_time;
    mem_wdata_o.yld    = req_q.yield_value;

    unique case (state_q)
      kmwt_pkg::ST_IDLE: begin
        idle_o = 1'b1;
        if (in_valid_i) begin
          req_d        = in_data_i;
          issue_idx_d  = cnt_m1[AW-1:0];
          issue_more_d = 1'b1;
          data_vld_d   = 1'b0;
          found_d      = 1'b0;
          pend_vld_d   = 1'b0;
          pend_d       = '0;
        end
      end

      kmwt_pkg::ST_WALK: begin
        emit_o.vld = list_push;
        emit_o.rsp = pend_q;
        if (adv) begin
          mem_re_o    = issue_more_q;
          data_vld_d  = issue_more_q;
          data_idx_d  = issue_idx_q;
          data_slot_d = slot;
          if (issue_more_q) begin
            if (issue_idx_q == '0) begin
              issue_more_d = 1'b0;
            end else begin
              issue_idx_d = issue_idx_q - AW'(1);
            end
          end
          if (is_srch && hit) begin
            // newest match found: stop issuing and keep the entry
            found_d              = 1'b1;
            found_slot_d         = data_slot_q;
            issue_more_d         = 1'b0;
            data_vld_d           = 1'b0;
            pend_d.accepted      = 1'b0;
            pend_d.entry_valid   = 1'b1;
            pend_d.position      = kmwt_pkg::PosW'(data_idx_q);
            pend_d.entry_time    = mem_rdata_i.tstamp;
            pend_d.entry_yield   = mem_rdata_i.yld;
            pend_d.last          = 1'b1;
          end
          if (is_list && list_hit) begin
            pend_vld_d           = 1'b1;
            pend_d.accepted      = 1'b0;
            pend_d.entry_valid   = 1'b1;
            pend_d.position      = kmwt_pkg::PosW'(data_idx_q);
            pend_d.entry_time    = mem_rdata_i.tstamp;
            pend_d.entry_yield   = mem_rdata_i.yld;
            pend_d.last          = 1'b0;
          end
        end
      end

      kmwt_pkg::ST_COMMIT: begin
        emit_o.vld      = 1'b1;
        emit_o.rsp.last = 1'b1;
        unique case (req_q.action)
          kmwt_pkg::ACT_LOAD: begin
            emit_o.rsp.accepted = has_room;
            if (emit_ok_i && has_room) begin
              mem_we_o = 1'b1;
              count_d  = count_q + CW'(1);
            end
          end
          kmwt_pkg::ACT_MERGE: begin
            emit_o.rsp.accepted = table_ready_i;
            if (emit_ok_i && table_ready_i) begin
              if (found_q) begin
                mem_we_o    = cmp.gt;
                mem_waddr_o = found_slot_q;
              end else if (has_room) begin
                mem_we_o = 1'b1;
                count_d  = count_q + CW'(1);
              end else begin
                // full: overwrite the oldest slot and advance the ring
                mem_we_o = 1'b1;
                oldest_d = (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + AW'(1);
              end
            end
          end
          kmwt_pkg::ACT_LOOKUP: begin
            if (found_q) begin
              emit_o.rsp = pend_q;
            end
          end
          kmwt_pkg::ACT_LIST: begin
            if (pend_vld_q) begin
              emit_o.rsp      = pend_q;
              emit_o.rsp.last = 1'b1;
            end
          end
          kmwt_pkg::ACT_CLEAR: begin
            emit_o.clr_ready = 1'b1;
            if (emit_ok_i) begin
              count_d  = '0;
              oldest_d = '0;
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kmwt_pkg::ST_IDLE;
      count_q      <= '0;
      oldest_q     <= '0;
      issue_more_q <= 1'b0;
      data_vld_q   <= 1'b0;
      found_q      <= 1'b0;
      pend_vld_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      oldest_q     <= oldest_d;
      issue_more_q <= issue_more_d;
      data_vld_q   <= data_vld_d;
      found_q      <= found_d;
      pend_vld_q   <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    pend_q       <= pend_d;
    issue_idx_q  <= issue_idx_d;
    data_idx_q   <= data_idx_d;
    data_slot_q  <= data_slot_d;
    found_slot_q <= found_slot_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_ring_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != '0) |-> (count_q == CW'(DEPTH)))
    else $error("ring rotated while table not full");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmwt_pkg::ST_WALK) |-> !mem_we_o)
    else $error("memory write during walk");

  a_read_data_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_vld_q |-> (state_q == kmwt_pkg::ST_WALK))
    else $error("read data pending outside walk");

  a_pend_list_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (req_q.action == kmwt_pkg::ACT_LIST))
    else $error("pending list entry for another action");

endmodule

### rtl/keyed_max_window_table.sv
// ----------------------------------------------------------------------------
// keyed_max_window_table: ring table of (timestamp, yield) pairs
// Load, merge (keep larger yield, evict oldest when full), lookup (newest
// match), list entries newer than a key (newest first) and clear.
// ----------------------------------------------------------------------------
//
//  channel   | signals                              | direction
//  ----------+--------------------------------------+-----------
//  request   | in_valid_i, in_stall_o, in_data_i    | in
//  response  | out_valid_o, out_stall_i, out_data_o | out
//  config    | cfg_we_i, cfg_data_i (table_ready)   | in
//
//  Skipping the walk: load, clear, undefined actions, merge or lookup with
//  the table not ready or empty, and list on an empty table go from the accept
//  state straight to commit. A walk over the occupied entries (at most DEPTH)
//  reads one entry per cycle, unless a list walk is held by the output, through
//  the single memory read port with registered read data, then commits. Merge
//  and lookup stop at the newest match.
//  One request is in flight at a time; in_stall_o is high until its final
//  response is loaded into the output register.
//  Reset clears count, ring pointer, table_ready, the sequencer state and its
//  flags; the entry memory is not cleared, only occupied entries are ever read.
//  A stalled output holds the walk of a list request whenever the next
//  qualifying entry is found while the previous one cannot leave.
// ----------------------------------------------------------------------------
module keyed_max_window_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kmwt_pkg::kmwt_req_t in_data_i,
  // response channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kmwt_pkg::kmwt_rsp_t out_data_o,
  // table_ready register write
  input  logic                cfg_we_i,
  input  logic                cfg_data_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                  table_ready_q, table_ready_d;
  logic                  out_vld_q, out_vld_d;
  kmwt_pkg::kmwt_rsp_t   out_q;
  logic                  idle;
  logic                  emit_ok;
  kmwt_pkg::kmwt_emit_t  emit;
  logic                  mem_re, mem_we;
  logic [AW-1:0]         mem_raddr, mem_waddr;
  kmwt_pkg::kmwt_entry_t mem_rdata, mem_wdata;

  kmwt_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  kmwt_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .idle_o        (idle),
    .table_ready_i (table_ready_q),
    .emit_o        (emit),
    .emit_ok_i     (emit_ok),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata)
  );

  // take a request only between requests
  assign in_stall_o = !idle;

  // output register: load when empty or being drained this cycle
  assign emit_ok = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit.vld && emit_ok) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // clear drops table_ready together with the table contents
  always_comb begin
    table_ready_d = table_ready_q;
    if (cfg_we_i) begin
      table_ready_d = cfg_data_i;
    end else if (emit.vld && emit.clr_ready && emit_ok) begin
      table_ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q     <= 1'b0;
      table_ready_q <= 1'b0;
    end else begin
      out_vld_q     <= out_vld_d;
      table_ready_q <= table_ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.vld && emit_ok) begin
      out_q <= emit.rsp;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while one is in flight");

  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.vld && emit_ok && emit.rsp.last) |=> !in_stall_o)
    else $error("input still stalled after final response");

  a_emit_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.vld |-> in_stall_o)
    else $error("response offered with no request in flight");

endmodule
